/* src/ehb_pkg.sv */
package ehb_pkg;

   localparam int KEY_W    = 8;
   localparam int HASH_W   = 28;
   localparam int LENGTH_W = 16;

   // words queued between the hash front end and the modulo back end
   localparam int QUEUE_DEPTH_DEF = 2;

   localparam logic [LENGTH_W-1:0] LENGTH_RESET = LENGTH_W'(17);

   typedef struct packed {
      logic [KEY_W-1:0] key_byte;
      logic             last_byte;
   } req_word_type;

   typedef struct packed {
      logic [HASH_W-1:0]   hash_value;
      logic [LENGTH_W-1:0] bucket_index;
   } rsp_word_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

   // one PJW step: h = (h << 4) + signed byte, fold the top nibble back in
   function automatic logic [HASH_W-1:0] mix_byte(input logic [HASH_W-1:0] h,
                                                  input logic [KEY_W-1:0]  b);
      logic [31:0] sum;
      logic [3:0]  g;
      sum = {h, 4'b0000} + {{(32-KEY_W){b[KEY_W-1]}}, b};
      g   = sum[31:28];
      return sum[HASH_W-1:0] ^ {{(HASH_W-8){1'b0}}, g, 4'b0000};
   endfunction

endpackage

/* src/ehb_front.sv */
module ehb_front
   import ehb_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  req_word_type      req_data,
   input  queue_stat_type    q_stat,
   output logic              req_full,
   output logic              q_push,
   output logic [HASH_W-1:0] q_hash
);

   logic [HASH_W-1:0] acc_ff, acc_in;
   logic              take;
   logic [HASH_W-1:0] mixed;

   assign req_full = q_stat.full;
   assign take     = req_push && !q_stat.full;
   assign mixed    = mix_byte(acc_ff, req_data.key_byte);
   assign q_push   = take && req_data.last_byte;
   assign q_hash   = mixed;

   always_comb begin
      acc_in = acc_ff;
      if (take) begin
         acc_in = req_data.last_byte ? '0 : mixed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

endmodule

/* src/ehb_queue.sv */
module ehb_queue
   import ehb_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
)(
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [HASH_W-1:0] push_hash,
   input  logic              pop,
   output logic [HASH_W-1:0] pop_hash,
   output queue_stat_type    stat
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [HASH_W-1:0] slot_ff [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              do_push, do_pop;

   assign stat.full  = (count_ff == CW'(DEPTH));
   assign stat.empty = (count_ff == '0);
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign pop_hash   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_hash;
      end
   end

endmodule

/* src/ehb_back.sv */
module ehb_back
   import ehb_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic [LENGTH_W-1:0] table_length,
   input  queue_stat_type      q_stat,
   input  logic [HASH_W-1:0]   q_hash,
   output logic                q_pop,
   input  logic                rsp_pop,
   output logic                rsp_empty,
   output rsp_word_type        rsp_data
);

   localparam int SW = $clog2(HASH_W);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type           state_ff, state_in;
   logic [SW-1:0]       step_ff, step_in;
   logic [HASH_W-1:0]   hash_ff, hash_in;
   logic [HASH_W-1:0]   dvd_ff, dvd_in;
   logic [LENGTH_W-1:0] dvsr_ff, dvsr_in;
   logic [LENGTH_W:0]   rem_ff, rem_in;
   logic [LENGTH_W:0]   rem_sh;
   logic                fits;
   logic                out_valid_ff, out_valid_in;
   rsp_word_type        out_ff, out_in;
   logic                load_out;

   // restoring divider, one quotient bit per cycle; only the remainder is kept
   assign rem_sh = {rem_ff[LENGTH_W-1:0], dvd_ff[HASH_W-1]};
   assign fits   = (rem_sh >= {1'b0, dvsr_ff});

   assign q_pop    = (state_ff == ST_IDLE) && !q_stat.empty;
   assign load_out = (state_ff == ST_DONE) && !out_valid_ff;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      hash_in  = hash_ff;
      dvd_in   = dvd_ff;
      dvsr_in  = dvsr_ff;
      rem_in   = rem_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!q_stat.empty) begin
               hash_in  = q_hash;
               dvd_in   = q_hash;
               dvsr_in  = table_length;
               rem_in   = '0;
               step_in  = SW'(HASH_W - 1);
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            dvd_in = {dvd_ff[HASH_W-2:0], 1'b0};
            rem_in = fits ? (rem_sh - {1'b0, dvsr_ff}) : rem_sh;
            if (step_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               step_in = step_ff - SW'(1);
            end
         end
         ST_DONE: begin
            if (!out_valid_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (out_valid_ff && rsp_pop) begin
         out_valid_in = 1'b0;
      end
      if (load_out) begin
         out_valid_in        = 1'b1;
         out_in.hash_value   = hash_ff;
         // zero table length gives bucket zero
         out_in.bucket_index = (dvsr_ff == '0) ? '0 : rem_ff[LENGTH_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      hash_ff <= hash_in;
      dvd_ff  <= dvd_in;
      dvsr_ff <= dvsr_in;
      rem_ff  <= rem_in;
      out_ff  <= out_in;
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

/* src/elf_hash_bucket_index.sv */
// A key's last word reaches rsp_data through the queue, the 28-step divider and the out reg.
// Throughput: req takes one key word per cycle while the queue is not full; the back end pops
// a new key only after the bit-serial modulo divider and the out reg are done with the last,
// so short keys back up through the queue to req_full.
// Reset (synchronous, active high): accumulator cleared, queue and result register emptied,
// table_length back to 17.
module elf_hash_bucket_index
   import ehb_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)(
   input  logic                clock,
   input  logic                reset,
   // key words
   input  logic                req_push,
   input  req_word_type        req_data,
   output logic                req_full,
   // result words
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output rsp_word_type        rsp_data,
   // table_length register
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [LENGTH_W-1:0] csr_data
);

   logic [LENGTH_W-1:0] length_ff, length_in;
   queue_stat_type      q_stat;
   logic                q_push, q_pop;
   logic [HASH_W-1:0]   q_in_hash, q_out_hash;

   // the user must write the register only while the block is idle (not enforced here), so no handshake stall
   assign csr_ready = 1'b1;
   assign length_in = (csr_valid && csr_ready) ? csr_data : length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= LENGTH_RESET;
      end else begin
         length_ff <= length_in;
      end
   end

   // front end: folds one key byte per word, hands the finished hash to the queue
   ehb_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .q_stat   (q_stat),
      .req_full (req_full),
      .q_push   (q_push),
      .q_hash   (q_in_hash)
   );

   // finished hashes waiting for the divider
   ehb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_hash (q_in_hash),
      .pop       (q_pop),
      .pop_hash  (q_out_hash),
      .stat      (q_stat)
   );

   // back end: hash mod table_length, then the result register
   ehb_back u_back (
      .clock        (clock),
      .reset        (reset),
      .table_length (length_ff),
      .q_stat       (q_stat),
      .q_hash       (q_out_hash),
      .q_pop        (q_pop),
      .rsp_pop      (rsp_pop),
      .rsp_empty    (rsp_empty),
      .rsp_data     (rsp_data)
   );

endmodule

/* src/ehb_checker.sv */
module ehb_checker
   import ehb_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_push,
   input  logic         req_full,
   input  logic         rsp_empty,
   input  logic         rsp_pop,
   input  rsp_word_type rsp_data
);

   // nothing waits on the result side right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result present after reset");

   // the input side fills up only through a pushed word
   a_full_needs_push: assert property (@(posedge clock) disable iff (reset)
      (!req_full && !req_push) |=> !req_full)
      else $error("input went full without a push");

   // a waiting word holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("result word changed while waiting");

   // result register refills only when it was empty, never in the cycle of a pop
   a_pop_drains: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop) |=> rsp_empty)
      else $error("result register reloaded on a pop");

   // a remainder never exceeds its dividend
   a_bucket_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> ({{(HASH_W-LENGTH_W){1'b0}}, rsp_data.bucket_index}
                      <= rsp_data.hash_value))
      else $error("bucket index above hash");

endmodule

bind elf_hash_bucket_index ehb_checker u_ehb_checker (
   .clock     (clock),
   .reset     (reset),
   .req_push  (req_push),
   .req_full  (req_full),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_data  (rsp_data)
);
